>>> design/ipk_pkg.sv
// ----------------------------------------------------------------------------
// ipk_pkg
// Shared types, codes and helpers of the iambic paddle keyer.
// ----------------------------------------------------------------------------
package ipk_pkg;

   // width of the countdown timer
   localparam int TIME_WIDTH     = 16;
   // width of the tick length registers
   localparam int TICKS_WIDTH    = 16;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_IDX_WIDTH  = 3;

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

   // keyer mode codes
   localparam logic [3:0] MODE_NONE         = 4'd0;
   localparam logic [3:0] MODE_STRAIGHT_L   = 4'd1;
   localparam logic [3:0] MODE_STRAIGHT_R   = 4'd2;
   localparam logic [3:0] MODE_STRAIGHT_ANY = 4'd3;
   localparam logic [3:0] MODE_SQZ_A        = 4'd4;
   localparam logic [3:0] MODE_SQZ_A_REV    = 4'd5;
   localparam logic [3:0] MODE_SQZ_B        = 4'd6;
   localparam logic [3:0] MODE_SQZ_B_REV    = 4'd7;
   localparam logic [3:0] MODE_BUG          = 4'd8;
   localparam logic [3:0] MODE_BUG_REV      = 4'd9;

   // word kinds on the request channel
   localparam logic KIND_PADDLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MODE   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ENABLE = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DIT    = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DASH   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_GUARD  = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SPACE  = 3'd5;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_DIT      = 4'd1,
      PH_DIT_GAP  = 4'd2,
      PH_DASH     = 4'd3,
      PH_DASH_GAP = 4'd4,
      PH_GUARD    = 4'd5,
      PH_SPACE    = 4'd6,
      PH_PASS_KEY = 4'd7,
      PH_PASS_GAP = 4'd8
   } phase_type;

   typedef struct packed {
      logic [3:0]             keyer_mode;
      logic                   keyer_enable;
      logic [TICKS_WIDTH-1:0] dit_ticks;
      logic [TICKS_WIDTH-1:0] dash_ticks;
      logic [TICKS_WIDTH-1:0] guard_ticks;
      logic [TICKS_WIDTH-1:0] space_ticks;
   } cfg_type;

   // load a tick length into the timer, saturating at its maximum
   function automatic logic [TIME_WIDTH-1:0] sat_ticks(input logic [TICKS_WIDTH-1:0] len);
      logic [TIME_WIDTH-1:0] r;
      if (32'(len) > 32'(TIME_MAX)) begin
         r = TIME_MAX;
      end else begin
         r = TIME_WIDTH'(len);
      end
      return r;
   endfunction

endpackage

>>> design/ipk_if.sv
// ----------------------------------------------------------------------------
// ipk channel interfaces
// Valid/ready channels for paddle/tick words and keyer result words.
// ----------------------------------------------------------------------------
interface ipk_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [1:0] paddles;

   modport source (output valid, output kind, output paddles, input ready);
   modport sink   (input valid, input kind, input paddles, output ready);
endinterface

interface ipk_rsp_if;
   logic       valid;
   logic       ready;
   logic       key_down;
   logic [3:0] keyer_phase;

   modport source (output valid, output key_down, output keyer_phase, input ready);
   modport sink   (input valid, input key_down, input keyer_phase, output ready);
endinterface

>>> design/iambic_paddle_keyer.sv
// Path: an accepted word enters the input register and moves, with its
// state update, into the result register once that register is free.
// Throughput: one word per cycle when not stalled; the state update is a single registered pass.
// The request side stalls only when both the input and result registers hold
// words and the result is not being taken.
// Reset (synchronous, active high): keyer idle, no result word valid, timer
// and memories cleared, registers at their default values.
// ----------------------------------------------------------------------------
// iambic_paddle_keyer
// Morse paddle keyer: straight, squeeze A/B and bug modes driven by paddle
// changes and timer ticks, with an APB-style register port.
// ----------------------------------------------------------------------------
module iambic_paddle_keyer import ipk_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   ipk_req_if.sink                   req_ch,
   ipk_rsp_if.source                 rsp_ch,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type cfg;

   ipk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ipk_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // key line follows the keyed phases
   a_key_matches_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.key_down == (rsp_ch.keyer_phase == PH_DIT ||
         rsp_ch.keyer_phase == PH_DASH || rsp_ch.keyer_phase == PH_PASS_KEY)))
      else $error("key_down does not match keyer_phase");

   // request side stalls only when both stages are full and output is blocked
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("request stalled with room in the pipeline");

   // no result word right after reset
   a_no_word_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result word valid right after reset");

endmodule

>>> design/ipk_csr.sv
// ----------------------------------------------------------------------------
// ipk_csr
// APB-style register file holding the keyer mode, enable and tick lengths.
// ----------------------------------------------------------------------------
module ipk_csr import ipk_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   logic [3:0]             mode_ff;
   logic                   enable_ff;
   logic [TICKS_WIDTH-1:0] dit_ff;
   logic [TICKS_WIDTH-1:0] dash_ff;
   logic [TICKS_WIDTH-1:0] guard_ff;
   logic [TICKS_WIDTH-1:0] space_ff;
   logic                   wr_en;
   logic [CSR_IDX_WIDTH-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_IDX_WIDTH+1:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SQZ_A;
         enable_ff <= 1'b0;
         dit_ff    <= 16'd100;
         dash_ff   <= 16'd300;
         guard_ff  <= 16'd50;
         space_ff  <= 16'd150;
      end else if (wr_en) begin
         case (reg_idx)
            REG_MODE:   mode_ff   <= csr_pwdata[3:0];
            REG_ENABLE: enable_ff <= csr_pwdata[0];
            REG_DIT:    dit_ff    <= csr_pwdata[TICKS_WIDTH-1:0];
            REG_DASH:   dash_ff   <= csr_pwdata[TICKS_WIDTH-1:0];
            REG_GUARD:  guard_ff  <= csr_pwdata[TICKS_WIDTH-1:0];
            REG_SPACE:  space_ff  <= csr_pwdata[TICKS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_MODE:   csr_prdata = CSR_DATA_WIDTH'(mode_ff);
         REG_ENABLE: csr_prdata = CSR_DATA_WIDTH'(enable_ff);
         REG_DIT:    csr_prdata = CSR_DATA_WIDTH'(dit_ff);
         REG_DASH:   csr_prdata = CSR_DATA_WIDTH'(dash_ff);
         REG_GUARD:  csr_prdata = CSR_DATA_WIDTH'(guard_ff);
         REG_SPACE:  csr_prdata = CSR_DATA_WIDTH'(space_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.keyer_mode   = mode_ff;
   assign cfg.keyer_enable = enable_ff;
   assign cfg.dit_ticks    = dit_ff;
   assign cfg.dash_ticks   = dash_ff;
   assign cfg.guard_ticks  = guard_ff;
   assign cfg.space_ticks  = space_ff;

endmodule

>>> design/ipk_core.sv
// ----------------------------------------------------------------------------
// ipk_core
// Input register, keyer state update and result register.
// ----------------------------------------------------------------------------
module ipk_core import ipk_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   ipk_req_if.sink   req_ch,
   ipk_rsp_if.source rsp_ch
);

   // pipeline control
   logic in_valid_ff, in_valid_in;
   logic in_kind_ff;
   logic [1:0] in_paddles_ff;
   logic out_valid_ff, out_valid_in;
   phase_type out_phase_ff;
   logic out_key_ff, out_key_in;
   logic out_free, step;

   // keyer state
   phase_type phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] time_ff, time_in;
   logic dit_held_ff, dit_held_in;
   logic dash_held_ff, dash_held_in;
   logic dit_mem_ff, dit_mem_in;
   logic dash_mem_ff, dash_mem_in;

   // decoded mode classes
   logic mode_straight, mode_squeeze, mode_none, mode_b;
   // paddle decode result
   logic dec_dit, dec_dash, dec_dit_mem, dec_dash_mem;
   // advance target
   phase_type adv_phase;
   logic [TICKS_WIDTH-1:0] adv_len;
   logic do_adv, timed;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign in_valid_in  = (req_ch.valid && req_ch.ready) || (in_valid_ff && !out_free);
   assign out_valid_in = step || (out_valid_ff && !rsp_ch.ready);

   assign mode_straight = cfg.keyer_mode inside {[MODE_STRAIGHT_L:MODE_STRAIGHT_ANY]};
   assign mode_squeeze  = cfg.keyer_mode inside {[MODE_SQZ_A:MODE_SQZ_B_REV]};
   assign mode_none     = !(cfg.keyer_mode inside {[MODE_STRAIGHT_L:MODE_BUG_REV]});
   assign mode_b        = cfg.keyer_mode >= MODE_SQZ_B;
   assign timed         = phase_ff inside {[PH_DIT:PH_SPACE]};

   // paddle decode and memory update
   always_comb begin
      dec_dit      = dit_held_ff;
      dec_dash     = dash_held_ff;
      dec_dit_mem  = dit_mem_ff;
      dec_dash_mem = dash_mem_ff;
      if (in_kind_ff == KIND_PADDLE) begin
         case (cfg.keyer_mode)
            MODE_STRAIGHT_L, MODE_SQZ_A, MODE_SQZ_B, MODE_BUG: begin
               dec_dit  = in_paddles_ff[0];
               dec_dash = in_paddles_ff[1];
            end
            MODE_STRAIGHT_R, MODE_SQZ_A_REV, MODE_SQZ_B_REV, MODE_BUG_REV: begin
               dec_dit  = in_paddles_ff[1];
               dec_dash = in_paddles_ff[0];
            end
            MODE_STRAIGHT_ANY: begin
               dec_dit  = |in_paddles_ff;
               dec_dash = 1'b0;
            end
            default: begin
               dec_dit  = 1'b0;
               dec_dash = 1'b0;
            end
         endcase
         dec_dit_mem  = 1'b0;
         dec_dash_mem = 1'b0;
         if (mode_squeeze) begin
            case (phase_ff)
               PH_DIT:      dec_dash_mem = mode_b && (dec_dash || dash_mem_ff);
               PH_DASH:     dec_dit_mem  = mode_b && (dec_dit || dit_mem_ff);
               PH_DIT_GAP:  dec_dash_mem = dec_dash || dash_mem_ff;
               PH_DASH_GAP: dec_dit_mem  = dec_dit || dit_mem_ff;
               default: ;
            endcase
         end
      end
   end

   // next phase when the keyer advances
   always_comb begin
      adv_phase = PH_IDLE;
      adv_len   = '0;
      if (mode_straight) begin
         if (phase_ff == PH_PASS_KEY) begin
            adv_phase = dec_dit ? PH_PASS_KEY : PH_PASS_GAP;
         end else if (dec_dit) begin
            adv_phase = PH_PASS_KEY;
         end else begin
            adv_phase = (phase_ff == PH_PASS_GAP) ? PH_PASS_GAP : PH_IDLE;
         end
      end else begin
         case (phase_ff)
            PH_DIT: begin
               adv_phase = PH_DIT_GAP;
               adv_len   = cfg.dit_ticks;
            end
            PH_DASH: begin
               adv_phase = PH_DASH_GAP;
               adv_len   = cfg.dit_ticks;
            end
            PH_DIT_GAP: begin
               if (mode_squeeze && (dec_dash || dec_dash_mem)) begin
                  adv_phase = PH_DASH;
                  adv_len   = cfg.dash_ticks;
               end else if (dec_dit) begin
                  adv_phase = PH_DIT;
                  adv_len   = cfg.dit_ticks;
               end else if (!mode_squeeze && dec_dash) begin
                  adv_phase = PH_DASH;
                  adv_len   = cfg.dash_ticks;
               end else begin
                  adv_phase = PH_GUARD;
                  adv_len   = cfg.guard_ticks;
               end
            end
            PH_DASH_GAP: begin
               if (mode_squeeze && (dec_dit || dec_dit_mem)) begin
                  adv_phase = PH_DIT;
                  adv_len   = cfg.dit_ticks;
               end else if (dec_dash) begin
                  adv_phase = PH_DASH;
                  adv_len   = cfg.dash_ticks;
               end else if (!mode_squeeze && dec_dit) begin
                  adv_phase = PH_DIT;
                  adv_len   = cfg.dit_ticks;
               end else begin
                  adv_phase = PH_GUARD;
                  adv_len   = cfg.guard_ticks;
               end
            end
            default: begin
               // a held paddle starts its element; else guard falls to space, everything else to idle
               if (dec_dit) begin
                  adv_phase = PH_DIT;
                  adv_len   = cfg.dit_ticks;
               end else if (dec_dash) begin
                  adv_phase = PH_DASH;
                  adv_len   = cfg.dash_ticks;
               end else if (phase_ff == PH_GUARD) begin
                  adv_phase = PH_SPACE;
                  adv_len   = cfg.space_ticks;
               end
            end
         endcase
      end
   end

   // when to advance
   always_comb begin
      if (in_kind_ff == KIND_TICK) begin
         do_adv = timed && (time_ff <= TIME_WIDTH'(1));
      end else if (mode_straight) begin
         do_adv = 1'b1;
      end else begin
         do_adv = (dec_dit || dec_dash) && (phase_ff == PH_IDLE || phase_ff > PH_SPACE);
      end
   end

   // next state
   always_comb begin
      phase_in     = phase_ff;
      time_in      = time_ff;
      dit_held_in  = dit_held_ff;
      dash_held_in = dash_held_ff;
      dit_mem_in   = dit_mem_ff;
      dash_mem_in  = dash_mem_ff;
      if (step) begin
         dit_held_in  = dec_dit;
         dash_held_in = dec_dash;
         dit_mem_in   = dec_dit_mem;
         dash_mem_in  = dec_dash_mem;
         if (!cfg.keyer_enable || mode_none) begin
            phase_in    = PH_IDLE;
            time_in     = '0;
            dit_mem_in  = 1'b0;
            dash_mem_in = 1'b0;
         end else if (do_adv) begin
            phase_in = adv_phase;
            time_in  = sat_ticks(adv_len);
            // a memory clears as its element starts
            if (adv_phase == PH_DIT) dit_mem_in = 1'b0;
            if (adv_phase == PH_DASH) dash_mem_in = 1'b0;
         end else if (in_kind_ff == KIND_TICK && timed) begin
            time_in = time_ff - TIME_WIDTH'(1);
         end
      end
   end

   // key line
   always_comb begin
      out_key_in = (phase_in == PH_DIT) || (phase_in == PH_DASH) || (phase_in == PH_PASS_KEY);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         time_ff      <= '0;
         dit_held_ff  <= 1'b0;
         dash_held_ff <= 1'b0;
         dit_mem_ff   <= 1'b0;
         dash_mem_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         time_ff      <= time_in;
         dit_held_ff  <= dit_held_in;
         dash_held_ff <= dash_held_in;
         dit_mem_ff   <= dit_mem_in;
         dash_mem_ff  <= dash_mem_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_kind_ff    <= req_ch.kind;
         in_paddles_ff <= req_ch.paddles;
      end
      if (step) begin
         out_phase_ff <= phase_in;
         out_key_ff   <= out_key_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.key_down    = out_key_ff;
   assign rsp_ch.keyer_phase = out_phase_ff;

endmodule

>>> dv/ipk_keyer_checker.sv
// ----------------------------------------------------------------------------
// ipk_keyer_checker
// Watches the request, result and register ports of the paddle keyer,
// tracks the keyer state and register settings, predicts the result word of
// every accepted request word and compares it field by field, in order.
// ----------------------------------------------------------------------------
module ipk_keyer_checker import ipk_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   ipk_req_if                        req_ch,
   ipk_rsp_if                        rsp_ch,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic                      csr_pready,
   output int                        fail_count,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic      key_down;
      phase_type phase;
   } keyer_word_type;

   // register copies
   logic [3:0]             mode_r;
   logic                   enable_r;
   logic [TICKS_WIDTH-1:0] dit_len, dash_len, guard_len, space_len;

   // keyer state
   phase_type             phase;
   logic [TIME_WIDTH-1:0] remaining;
   logic                  dit_on, dash_on, dit_mem, dash_mem;

   keyer_word_type keyer_out_q[$];
   int             errors = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic bit is_straight();
      return mode_r >= MODE_STRAIGHT_L && mode_r <= MODE_STRAIGHT_ANY;
   endfunction

   function automatic bit is_squeeze();
      return mode_r >= MODE_SQZ_A && mode_r <= MODE_SQZ_B_REV;
   endfunction

   function automatic bit is_off();
      return mode_r == MODE_NONE || mode_r > MODE_BUG_REV;
   endfunction

   function automatic void clear_keyer();
      mode_r    = MODE_SQZ_A;
      enable_r  = 1'b0;
      dit_len   = 16'd100;
      dash_len  = 16'd300;
      guard_len = 16'd50;
      space_len = 16'd150;
      phase     = PH_IDLE;
      remaining = '0;
      dit_on    = 1'b0;
      dash_on   = 1'b0;
      dit_mem   = 1'b0;
      dash_mem  = 1'b0;
   endfunction

   // enter a phase; the timer is as wide as the length registers, so no clamp
   function automatic void enter(input phase_type ph, input logic [TICKS_WIDTH-1:0] len);
      phase     = ph;
      remaining = TIME_WIDTH'(len);
      if (ph == PH_DIT) begin
         dit_mem = 1'b0;
      end
      if (ph == PH_DASH) begin
         dash_mem = 1'b0;
      end
   endfunction

   function automatic void start_or(input phase_type ph, input logic [TICKS_WIDTH-1:0] len);
      if (dit_on) begin
         enter(PH_DIT, dit_len);
      end else if (dash_on) begin
         enter(PH_DASH, dash_len);
      end else begin
         enter(ph, len);
      end
   endfunction

   // pick the phase that follows the current one
   function automatic void next_phase();
      if (is_straight()) begin
         if (phase == PH_PASS_KEY) begin
            enter(dit_on ? PH_PASS_KEY : PH_PASS_GAP, '0);
         end else if (dit_on) begin
            enter(PH_PASS_KEY, '0);
         end else if (phase == PH_PASS_GAP) begin
            enter(PH_PASS_GAP, '0);
         end else begin
            enter(PH_IDLE, '0);
         end
         return;
      end
      case (phase)
         PH_GUARD: start_or(PH_SPACE, space_len);
         PH_DIT:   enter(PH_DIT_GAP, dit_len);
         PH_DASH:  enter(PH_DASH_GAP, dit_len);
         PH_DIT_GAP: begin
            if (is_squeeze()) begin
               if (dash_on || dash_mem) enter(PH_DASH, dash_len);
               else if (dit_on)         enter(PH_DIT, dit_len);
               else                     enter(PH_GUARD, guard_len);
            end else begin
               if (dit_on)       enter(PH_DIT, dit_len);
               else if (dash_on) enter(PH_DASH, dash_len);
               else              enter(PH_GUARD, guard_len);
            end
         end
         PH_DASH_GAP: begin
            if (is_squeeze()) begin
               if (dit_on || dit_mem) enter(PH_DIT, dit_len);
               else if (dash_on)      enter(PH_DASH, dash_len);
               else                   enter(PH_GUARD, guard_len);
            end else begin
               if (dash_on)     enter(PH_DASH, dash_len);
               else if (dit_on) enter(PH_DIT, dit_len);
               else             enter(PH_GUARD, guard_len);
            end
         end
         default: start_or(PH_IDLE, '0);
      endcase
   endfunction

   // paddle decode and squeeze memories
   function automatic void take_paddles(input logic [1:0] pads);
      logic left, right, mode_b;
      left  = pads[0];
      right = pads[1];
      case (mode_r)
         MODE_STRAIGHT_L, MODE_SQZ_A, MODE_SQZ_B, MODE_BUG: begin
            dit_on  = left;
            dash_on = right;
         end
         MODE_STRAIGHT_R, MODE_SQZ_A_REV, MODE_SQZ_B_REV, MODE_BUG_REV: begin
            dit_on  = right;
            dash_on = left;
         end
         MODE_STRAIGHT_ANY: begin
            dit_on  = left | right;
            dash_on = 1'b0;
         end
         default: begin
            dit_on  = 1'b0;
            dash_on = 1'b0;
         end
      endcase
      if (!is_squeeze()) begin
         dit_mem  = 1'b0;
         dash_mem = 1'b0;
         return;
      end
      mode_b = mode_r >= MODE_SQZ_B;
      case (phase)
         PH_DIT: begin
            dit_mem  = 1'b0;
            dash_mem = mode_b ? (dash_on | dash_mem) : 1'b0;
         end
         PH_DASH: begin
            dit_mem  = mode_b ? (dit_on | dit_mem) : 1'b0;
            dash_mem = 1'b0;
         end
         PH_DIT_GAP: begin
            dit_mem  = 1'b0;
            dash_mem = dash_on | dash_mem;
         end
         PH_DASH_GAP: begin
            dit_mem  = dit_on | dit_mem;
            dash_mem = 1'b0;
         end
         default: begin
            dit_mem  = 1'b0;
            dash_mem = 1'b0;
         end
      endcase
   endfunction

   // advance the keyer by one request word and give its result word
   function automatic keyer_word_type step_keyer(input logic kind, input logic [1:0] pads);
      keyer_word_type w;
      if (kind == KIND_PADDLE) begin
         take_paddles(pads);
      end
      if (!enable_r || is_off()) begin
         phase     = PH_IDLE;
         remaining = '0;
         dit_mem   = 1'b0;
         dash_mem  = 1'b0;
      end else if (kind == KIND_TICK) begin
         if (phase >= PH_DIT && phase <= PH_SPACE) begin
            if (remaining <= 1) begin
               remaining = '0;
               next_phase();
            end else begin
               remaining = remaining - 1'b1;
            end
         end
      end else if (is_straight()) begin
         next_phase();
      end else if ((dit_on || dash_on) && (phase == PH_IDLE || phase > PH_SPACE)) begin
         next_phase();
      end
      w.key_down = phase == PH_DIT || phase == PH_DASH || phase == PH_PASS_KEY;
      w.phase    = phase;
      return w;
   endfunction

   always @(posedge clock) begin
      keyer_word_type want;
      if (reset) begin
         clear_keyer();
         keyer_out_q.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_WIDTH-1:2])
               REG_MODE:   mode_r    = csr_pwdata[3:0];
               REG_ENABLE: enable_r  = csr_pwdata[0];
               REG_DIT:    dit_len   = csr_pwdata[TICKS_WIDTH-1:0];
               REG_DASH:   dash_len  = csr_pwdata[TICKS_WIDTH-1:0];
               REG_GUARD:  guard_len = csr_pwdata[TICKS_WIDTH-1:0];
               REG_SPACE:  space_len = csr_pwdata[TICKS_WIDTH-1:0];
               default: ;
            endcase
         end
         // result side
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (keyer_out_q.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               want = keyer_out_q.pop_front();
               if (rsp_ch.key_down !== want.key_down) begin
                  report_mismatch($sformatf("key_down got %b want %b",
                                            rsp_ch.key_down, want.key_down));
               end
               if (rsp_ch.keyer_phase !== 4'(want.phase)) begin
                  report_mismatch($sformatf("keyer_phase got %0d want %0d",
                                            rsp_ch.keyer_phase, want.phase));
               end
            end
         end
         // request side
         if (req_ch.valid && req_ch.ready) begin
            keyer_out_q.push_back(step_keyer(req_ch.kind, req_ch.paddles));
         end
      end
      outstanding <= keyer_out_q.size();
      fail_count  <= errors;
   end

endmodule

>>> dv/iambic_paddle_keyer_test.sv
// ----------------------------------------------------------------------------
// iambic_paddle_keyer_test
// Drives paddle and tick words into the keyer through a run of register
// settings (every mode, disabled, extreme and zero lengths), with random
// gaps on the request side and random stalls on the result side. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module iambic_paddle_keyer_test import ipk_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PLAN_ROWS   = 16;
   localparam int ROW_WORDS   = 120;

   typedef struct {
      logic [3:0]             mode;
      logic                   enable;
      logic [TICKS_WIDTH-1:0] dit, dash, guard, space;
   } setting_type;

   logic clock = 1'b0;
   logic reset;

   logic                      csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata, csr_prdata;

   int fail_count, outstanding;
   int cycle_count = 0;
   bit steady = 1'b0;

   ipk_req_if req_ch();
   ipk_rsp_if rsp_ch();

   iambic_paddle_keyer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ipk_keyer_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side stalls, none in a quiet window
   always @(posedge clock) begin
      if (cycle_count >= 800 && cycle_count < 1600) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= $urandom_range(0, 99) >= 6;
      end
   end

   // one word on the request channel, with an occasional gap first
   task automatic send_word(input logic kind, input logic [1:0] pads);
      if (!steady && $urandom_range(0, 99) < 6) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.paddles <= pads;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // drop valid and wait for every result word
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_keyer(input setting_type s);
      csr_write(REG_MODE, 32'(s.mode));
      csr_write(REG_ENABLE, 32'(s.enable));
      csr_write(REG_DIT, 32'(s.dit));
      csr_write(REG_DASH, 32'(s.dash));
      csr_write(REG_GUARD, 32'(s.guard));
      csr_write(REG_SPACE, 32'(s.space));
   endtask

   // mostly a paddle change held over a run of ticks, some loose words
   task automatic random_traffic(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 85) begin
            send_word(KIND_PADDLE, 2'($urandom_range(0, 3)));
            sent++;
            repeat ($urandom_range(0, 8)) begin
               send_word(KIND_TICK, 2'($urandom_range(0, 3)));
               sent++;
            end
         end else begin
            send_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            sent++;
         end
      end
   endtask

   initial begin
      setting_type plan[PLAN_ROWS];
      setting_type row;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.kind    <= KIND_PADDLE;
      req_ch.paddles <= 2'b00;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;

      plan[0]  = '{MODE_SQZ_A,        1'b1, 16'd1, 16'd3, 16'd1, 16'd2};
      plan[1]  = '{MODE_SQZ_A_REV,    1'b1, 16'd2, 16'd5, 16'd1, 16'd3};
      plan[2]  = '{MODE_SQZ_B,        1'b1, 16'd1, 16'd2, 16'd2, 16'd1};
      // zero lengths behave as one tick
      plan[3]  = '{MODE_SQZ_B_REV,    1'b1, 16'd0, 16'd1, 16'd0, 16'd0};
      plan[4]  = '{MODE_BUG,          1'b1, 16'd2, 16'd4, 16'd1, 16'd1};
      plan[5]  = '{MODE_BUG_REV,      1'b1, 16'd1, 16'd3, 16'd2, 16'd2};
      plan[6]  = '{MODE_STRAIGHT_L,   1'b1, 16'd1, 16'd2, 16'd1, 16'd1};
      plan[7]  = '{MODE_STRAIGHT_R,   1'b1, 16'd3, 16'd1, 16'd2, 16'd2};
      plan[8]  = '{MODE_STRAIGHT_ANY, 1'b1, 16'd1, 16'd3, 16'd1, 16'd2};
      plan[9]  = '{MODE_NONE,         1'b1, 16'd1, 16'd3, 16'd1, 16'd2};
      // undefined mode code acts as none
      plan[10] = '{4'd12,             1'b1, 16'd1, 16'd3, 16'd1, 16'd2};
      plan[11] = '{MODE_SQZ_B,        1'b0, 16'd1, 16'd3, 16'd1, 16'd2};
      plan[12] = '{MODE_SQZ_A,        1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      for (int i = 13; i < PLAN_ROWS; i++) begin
         plan[i] = '{4'($urandom_range(0, 9)), 1'b1, 16'($urandom_range(1, 5)),
                     16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)),
                     16'($urandom_range(1, 5))};
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset: key stays up whatever the paddles do
      for (int p = 0; p < 4; p++) begin
         send_word(KIND_PADDLE, 2'(p));
      end
      send_word(KIND_TICK, 2'b11);
      settle();

      // enabled with the reset mode and lengths
      csr_write(REG_ENABLE, 32'd1);
      send_word(KIND_PADDLE, 2'b01);
      send_word(KIND_TICK, 2'b00);
      send_word(KIND_TICK, 2'b00);
      send_word(KIND_PADDLE, 2'b00);
      send_word(KIND_PADDLE, 2'b11);
      send_word(KIND_TICK, 2'b00);
      settle();

      // squeeze B with short lengths: both paddles, then release mid-element
      row = '{MODE_SQZ_B, 1'b1, 16'd1, 16'd2, 16'd1, 16'd1};
      program_keyer(row);
      send_word(KIND_PADDLE, 2'b11);
      repeat (8) send_word(KIND_TICK, 2'b00);
      send_word(KIND_PADDLE, 2'b00);
      repeat (4) send_word(KIND_TICK, 2'b00);
      settle();

      // random part over the setting plan
      for (int i = 0; i < PLAN_ROWS; i++) begin
         program_keyer(plan[i]);
         steady = i == 2;
         random_traffic(i == 12 ? 40 : ROW_WORDS);
         steady = 1'b0;
         settle();
      end

      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
